[hdl/tasd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tasd_pkg;

  localparam int DELTA_WIDTH  = 16;
  localparam int THR_WIDTH    = 15;
  localparam int WIN_WIDTH    = 5;
  localparam int LIMIT_WIDTH  = 5;
  localparam int COUNT_WIDTH  = 5;
  localparam int CFG_IDX_WIDTH = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_WINDOW    = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_LIMIT     = 2'd2;

  localparam logic [THR_WIDTH-1:0]   THRESHOLD_RST = 15'd8;
  localparam logic [WIN_WIDTH-1:0]   WINDOW_RST    = 5'd16;
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RST     = 5'd6;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Three-way sign codes
  localparam logic [1:0] SGN_ZERO = 2'b00;
  localparam logic [1:0] SGN_POS  = 2'b01;
  localparam logic [1:0] SGN_NEG  = 2'b11;

  typedef struct packed {
    logic signed [DELTA_WIDTH-1:0] delta_x;
    logic signed [DELTA_WIDTH-1:0] delta_y;
    logic                          holding;
  } in_t;

  typedef struct packed {
    logic                   shake;
    logic [COUNT_WIDTH-1:0] change_count;
  } out_t;

  typedef struct packed {
    logic load;      // capture the accepted transaction
    logic push;      // append the new sample pair to the windows
    logic rd_issue;  // read the next window entry
    logic finish;    // result taken into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic holding;
    logic rd_last;
  } dp_sts_t;

  function automatic logic [1:0] sign3(input logic signed [DELTA_WIDTH-1:0] d);
    logic [1:0] s;
    if (d[DELTA_WIDTH-1]) begin
      s = SGN_NEG;
    end else if (d == '0) begin
      s = SGN_ZERO;
    end else begin
      s = SGN_POS;
    end
    return s;
  endfunction

  function automatic logic exceeds(input logic signed [DELTA_WIDTH-1:0] d,
                                   input logic [THR_WIDTH-1:0] thr);
    logic [DELTA_WIDTH:0] ext;
    logic [DELTA_WIDTH:0] mag;
    ext = {d[DELTA_WIDTH-1], d};
    mag = d[DELTA_WIDTH-1] ? (~ext + (DELTA_WIDTH+1)'(1)) : ext;
    return mag > (DELTA_WIDTH+1)'(thr);
  endfunction

endpackage

`default_nettype wire

[hdl/tasd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module tasd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             out_free,
  input  wire tasd_pkg::dp_sts_t sts,
  output tasd_pkg::dp_cmd_t     cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PUSH  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        // a transaction without hold touches no state
        if (sts.holding) begin
          cmd.push  = 1'b1;
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        if (sts.rd_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/tasd_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module tasd_dp #(
  parameter int WINDOW_DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire tasd_pkg::dp_cmd_t                    cmd,
  output tasd_pkg::dp_sts_t                         sts,
  input  wire tasd_pkg::in_t                        in_data,
  input  wire logic [tasd_pkg::THR_WIDTH-1:0]       cfg_threshold,
  input  wire logic [tasd_pkg::WIN_WIDTH-1:0]       cfg_window,
  input  wire logic [tasd_pkg::LIMIT_WIDTH-1:0]     cfg_limit,
  output tasd_pkg::out_t                            result
);

  localparam int DW = tasd_pkg::DELTA_WIDTH;
  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int SW = CW + 1;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                             input logic [CW-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s >= SW'(WINDOW_DEPTH)) begin
      s = s - SW'(WINDOW_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // X in the upper half, Y in the lower half of each word
  logic [2*DW-1:0] mem [WINDOW_DEPTH];

  tasd_pkg::in_t in_r;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          rd_vld_r;
  logic          rd_first_r;
  logic [2*DW-1:0] rd_data_r;
  logic [1:0]    prev_x_r, prev_y_r;
  logic [tasd_pkg::COUNT_WIDTH-1:0] cnt_r, cnt_nxt;

  logic [CW-1:0] win_eff;
  logic          full;
  logic [CW-1:0] drop;
  logic [CW-1:0] keep;
  logic [AW-1:0] head_new;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic signed [DW-1:0] cur_x, cur_y;
  logic          hit_x, hit_y;
  logic [tasd_pkg::COUNT_WIDTH:0] cnt_sum;

  // Clamp the window size into 1..WINDOW_DEPTH
  always_comb begin
    if (cfg_window == '0) begin
      win_eff = CW'(1);
    end else if (int'(cfg_window) > WINDOW_DEPTH) begin
      win_eff = CW'(WINDOW_DEPTH);
    end else begin
      win_eff = CW'(cfg_window);
    end
  end

  // When full, drop the oldest entries so that the new sample leaves exactly win_eff
  assign full     = (fill_r >= win_eff);
  assign drop     = fill_r - win_eff + CW'(1);
  assign keep     = full ? (win_eff - CW'(1)) : fill_r;
  assign head_new = full ? wrap_add(head_r, drop) : head_r;
  assign wr_addr  = wrap_add(head_new, keep);
  assign rd_addr  = wrap_add(head_r, rd_idx_r);

  assign sts.holding = in_r.holding;
  assign sts.rd_last = ((SW'(rd_idx_r) + SW'(1)) == SW'(fill_r));

  assign cur_x = rd_data_r[2*DW-1:DW];
  assign cur_y = rd_data_r[DW-1:0];
  assign hit_x = !rd_first_r && tasd_pkg::exceeds(cur_x, cfg_threshold) &&
                 (tasd_pkg::sign3(cur_x) != prev_x_r);
  assign hit_y = !rd_first_r && tasd_pkg::exceeds(cur_y, cfg_threshold) &&
                 (tasd_pkg::sign3(cur_y) != prev_y_r);
  assign cnt_sum = {1'b0, cnt_r} + {{tasd_pkg::COUNT_WIDTH{1'b0}}, hit_x}
                                 + {{tasd_pkg::COUNT_WIDTH{1'b0}}, hit_y};

  assign result.change_count = cnt_r;
  assign result.shake        = in_r.holding && (cnt_r >= cfg_limit);

  always_comb begin
    fill_nxt   = fill_r;
    head_nxt   = head_r;
    rd_idx_nxt = rd_idx_r;
    cnt_nxt    = cnt_r;
    if (cmd.push) begin
      fill_nxt   = keep + CW'(1);
      head_nxt   = head_new;
      rd_idx_nxt = '0;
    end
    if (cmd.rd_issue) begin
      rd_idx_nxt = rd_idx_r + CW'(1);
    end
    if (cmd.finish && result.shake) begin
      fill_nxt = '0;
    end
    if (cmd.load) begin
      cnt_nxt = '0;
    end else if (rd_vld_r) begin
      cnt_nxt = cnt_sum[tasd_pkg::COUNT_WIDTH] ? tasd_pkg::COUNT_MAX
                                               : cnt_sum[tasd_pkg::COUNT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      head_r   <= '0;
      rd_idx_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      fill_r   <= fill_nxt;
      head_r   <= head_nxt;
      rd_idx_r <= rd_idx_nxt;
      rd_vld_r <= cmd.rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
    end
    cnt_r <= cnt_nxt;
    if (rd_vld_r) begin
      prev_x_r <= tasd_pkg::sign3(cur_x);
      prev_y_r <= tasd_pkg::sign3(cur_y);
    end
    rd_first_r <= (rd_idx_r == '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= {in_r.delta_x, in_r.delta_y};
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hdl/two_axis_shake_detector_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Shake detector over X/Y motion deltas. Each accepted transaction with
// holding set appends one X and one Y sample to per-axis sliding windows
// (window_samples deep, clamped to 1..WINDOW_DEPTH), then walks the window
// oldest to newest and counts direction changes: a sample whose magnitude
// is above shake_threshold and whose sign (-, 0, +) differs from the
// previous sample's. Both axes add into one count that saturates at 31.
// When the count reaches change_limit, shake is reported and both windows
// are emptied. Transactions with holding clear return shake = 0 and a zero
// count and leave the windows as they are. Every input transaction yields
// exactly one result transaction. A holding transaction walks the window,
// reading its fill entries one per cycle from a single-port window memory,
// where fill is the number of samples in the window after the new one is
// appended (up to WINDOW_DEPTH); a transaction without hold has no walk.
// One transaction is in work at a time; the next may be accepted while the
// previous result still waits in the output register. Configuration writes
// are always ready and must only be issued while the block is idle.

module two_axis_shake_detector_core #(
  parameter int WINDOW_DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // input transactions
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire tasd_pkg::in_t                         in_data,
  // result transactions
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output tasd_pkg::out_t                             out_data,
  // configuration writes
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [tasd_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
  input  wire logic [31:0]                           cfg_data
);

  logic [tasd_pkg::THR_WIDTH-1:0]   threshold_r;
  logic [tasd_pkg::WIN_WIDTH-1:0]   window_r;
  logic [tasd_pkg::LIMIT_WIDTH-1:0] limit_r;

  tasd_pkg::dp_cmd_t cmd;
  tasd_pkg::dp_sts_t sts;
  tasd_pkg::out_t    result;

  logic           out_valid_r;
  tasd_pkg::out_t out_data_r;
  logic           out_free;

  // Register file takes a write every cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= tasd_pkg::THRESHOLD_RST;
      window_r    <= tasd_pkg::WINDOW_RST;
      limit_r     <= tasd_pkg::LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tasd_pkg::CFG_THRESHOLD: threshold_r <= cfg_data[tasd_pkg::THR_WIDTH-1:0];
        tasd_pkg::CFG_WINDOW:    window_r    <= cfg_data[tasd_pkg::WIN_WIDTH-1:0];
        tasd_pkg::CFG_LIMIT:     limit_r     <= cfg_data[tasd_pkg::LIMIT_WIDTH-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Output register is free when empty or when its transaction goes out now
  assign out_free = !out_valid_r || !out_stall;

  tasd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  tasd_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_data       (in_data),
    .cfg_threshold (threshold_r),
    .cfg_window    (window_r),
    .cfg_limit     (limit_r),
    .result        (result)
  );

  // Hold the result until taken; the controller only finishes into a free slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[hdl/tasd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module tasd_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_stall,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire tasd_pkg::out_t                     out_data
);

  // A stalled result stays valid and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  // One transaction in work at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a transaction is in work");

  // A result cannot appear in the cycle right after an accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared without processing time");

  // Reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind two_axis_shake_detector_core tasd_checker u_tasd_checker (.*);

`default_nettype wire

[sim/tb_two_axis_shake_detector_core.sv]
`timescale 1ns / 1ps

module tb_two_axis_shake_detector_core;

  localparam int HIST_DEPTH  = 16;      // matches the core's default WINDOW_DEPTH
  localparam int CYCLE_LIMIT = 400000;  // far above the slowest legal run
  localparam int NUM_PHASES  = 12;
  localparam int PHASE_MOVES = 75;

  localparam int DELTA_W = tasd_pkg::DELTA_WIDTH;
  localparam int COUNT_W = tasd_pkg::COUNT_WIDTH;
  localparam int THR_W   = tasd_pkg::THR_WIDTH;
  localparam int WIN_W   = tasd_pkg::WIN_WIDTH;
  localparam int LIMIT_W = tasd_pkg::LIMIT_WIDTH;

  logic clk;
  logic rst_n;

  logic                               in_valid;
  logic                               in_stall;
  tasd_pkg::in_t                      in_data;
  logic                               out_valid;
  logic                               out_stall;
  tasd_pkg::out_t                     out_data;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [tasd_pkg::CFG_IDX_WIDTH-1:0] cfg_index;
  logic [31:0]                        cfg_data;

  two_axis_shake_detector_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock, low half first so that the first rising edge comes after
  // the initial block has set every input.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Shadow of the core: register copies, both sample histories and the fill
  // level. Updated only by the driver (per accepted transaction) and by the
  // register write task (while the core is idle).
  int unsigned thr_reg;
  int unsigned win_reg;
  int unsigned lim_reg;
  logic signed [DELTA_W-1:0] x_hist [HIST_DEPTH];
  logic signed [DELTA_W-1:0] y_hist [HIST_DEPTH];
  int unsigned fill_level;

  tasd_pkg::in_t  pending_moves[$];     // motion transactions not yet offered
  tasd_pkg::out_t expected_shakes[$];   // predicted results, oldest first

  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned error_count;
  int unsigned cycle_count;

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $realtime, what);
    error_count++;
  endtask

  function automatic int direction_of(input int v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  // A pair counts when the newer sample is strictly above the threshold in
  // magnitude and points another way (negative, zero, positive) than the older.
  function automatic bit is_reversal(input int newer, input int older);
    int mag;
    mag = (newer < 0) ? -newer : newer;
    return (mag > int'(thr_reg)) && (direction_of(newer) != direction_of(older));
  endfunction

  // Work out the result of one motion transaction and advance the shadow state.
  function automatic tasd_pkg::out_t predict_shake(input tasd_pkg::in_t mv);
    tasd_pkg::out_t res;
    int   win;
    int   n;
    int   drop;
    int   cnt;
    int   i;
    res = '0;
    if (!mv.holding) begin
      return res;
    end
    // Clamp the window register: zero acts as one, oversize saturates.
    win = int'(win_reg);
    if (win < 1) begin
      win = 1;
    end
    if (win > HIST_DEPTH) begin
      win = HIST_DEPTH;
    end
    n = int'(fill_level);
    // Full (or over-full after a shrink): drop the oldest so that the new
    // sample leaves exactly win entries.
    if (n >= win) begin
      drop = n - win + 1;
      for (i = 0; i < win - 1; i++) begin
        x_hist[i] = x_hist[i + drop];
        y_hist[i] = y_hist[i + drop];
      end
      n = win - 1;
    end
    x_hist[n] = mv.delta_x;
    y_hist[n] = mv.delta_y;
    n++;
    fill_level = n;
    cnt = 0;
    for (i = 1; i < n; i++) begin
      if (is_reversal(int'(x_hist[i]), int'(x_hist[i - 1]))) begin
        cnt++;
      end
      if (is_reversal(int'(y_hist[i]), int'(y_hist[i - 1]))) begin
        cnt++;
      end
    end
    if (cnt > 31) begin
      cnt = 31;
    end
    res.change_count = COUNT_W'(cnt);
    if (cnt >= int'(lim_reg)) begin
      res.shake  = 1'b1;
      fill_level = 0;
    end
    return res;
  endfunction

  // Input driver. Offer a new transaction whenever the slot is empty or the
  // current one is taken this edge; hold the payload while stalled. Predict
  // each transaction at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        expected_shakes.push_back(predict_shake(in_data));
      end
      if (pending_moves.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_moves.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor. Compare every accepted result against the oldest
  // prediction, then pick a fresh stall value for the next edge.
  always @(posedge clk) begin : result_check
    tasd_pkg::out_t oldest;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_shakes.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding: shake=%0b count=%0d",
                                    out_data.shake, out_data.change_count));
        end else begin
          oldest = expected_shakes.pop_front();
          if (out_data.shake !== oldest.shake) begin
            report_mismatch($sformatf("shake: got %0b, want %0b",
                                      out_data.shake, oldest.shake));
          end
          if (out_data.change_count !== oldest.change_count) begin
            report_mismatch($sformatf("change_count: got %0d, want %0d",
                                      out_data.change_count, oldest.change_count));
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  // Watchdog: end the run if the core hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("two_axis_shake_detector_core regression: fail");
      $finish;
    end
  end

  task automatic queue_move(input int dx, input int dy, input bit hold);
    tasd_pkg::in_t mv;
    mv.delta_x = DELTA_W'(dx);
    mv.delta_y = DELTA_W'(dy);
    mv.holding = hold;
    pending_moves.push_back(mv);
  endtask

  // Wait until every queued transaction is taken and every result is back.
  task automatic wait_drained();
    while (pending_moves.size() != 0 || in_valid || expected_shakes.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Write all three registers back to back. Keep cfg_valid high across the
  // burst and drop it only once, after the last write. Fill the unused upper
  // data bits with noise; the core keeps only the register's width.
  task automatic write_registers(input int unsigned thr, input int unsigned win,
                                 input int unsigned lim);
    logic [31:0] word;
    int          k;
    for (k = 0; k < 3; k++) begin
      word = $urandom;
      case (k)
        0: begin
          word[THR_W-1:0] = THR_W'(thr);
          cfg_index <= tasd_pkg::CFG_THRESHOLD;
          thr_reg    = word[THR_W-1:0];
        end
        1: begin
          word[WIN_W-1:0] = WIN_W'(win);
          cfg_index <= tasd_pkg::CFG_WINDOW;
          win_reg    = word[WIN_W-1:0];
        end
        default: begin
          word[LIMIT_W-1:0] = LIMIT_W'(lim);
          cfg_index <= tasd_pkg::CFG_LIMIT;
          lim_reg    = word[LIMIT_W-1:0];
        end
      endcase
      cfg_data  <= word;
      cfg_valid <= 1'b1;
      do begin
        @(posedge clk);
      end while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // Pick one axis delta. Half the time keep an oscillation going (opposite
  // direction, above threshold) so that windows reach the limit; the rest
  // covers threshold edges, zero, full-range noise and the extreme codes.
  function automatic int pick_delta(inout bit going_neg);
    int kind;
    int mag;
    kind = $urandom_range(0, 99);
    if (kind < 50) begin
      going_neg = !going_neg;
      mag = int'(thr_reg) + 1 + $urandom_range(0, 200);
      if (mag > 32768) begin
        mag = 32768;
      end
      return going_neg ? -mag : mag;
    end else if (kind < 65) begin
      mag = int'(thr_reg) - 1 + $urandom_range(0, 2);
      if (mag < 0) begin
        mag = 0;
      end
      return $urandom_range(0, 1) ? -mag : mag;
    end else if (kind < 75) begin
      return 0;
    end else if (kind < 90) begin
      return int'($signed(16'($urandom)));
    end else begin
      case ($urandom_range(0, 4))
        0:       return -32768;
        1:       return 32767;
        2:       return -32767;
        3:       return 1;
        default: return -1;
      endcase
    end
  endfunction

  // Register settings per phase; negative entries mean pick at random.
  // The phase with window 31 and an unreachable limit leaves both
  // histories full, so the next phase shrinks a full window.
  int phase_thr [NUM_PHASES] = '{8, 0, 32767, 20, 5, 100, 10, 50, 12, 0, -1, -1};
  int phase_win [NUM_PHASES] = '{16, 2, 16, 31, 4, 0, 1, 9, 16, 17, -1, -1};
  int phase_lim [NUM_PHASES] = '{6, 1, 30, 31, 3, 0, 5, 8, 4, 31, -1, -1};

  initial begin
    int          p;
    int          m;
    int          dx;
    int          dy;
    bit          x_neg;
    bit          y_neg;
    int unsigned thr;
    int unsigned win;
    int unsigned lim;

    // Drive every input to a known value before the first edge.
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_data            = '0;
    out_stall          = 1'b0;
    cfg_valid          = 1'b0;
    cfg_index          = tasd_pkg::CFG_THRESHOLD;
    cfg_data           = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    error_count        = 0;
    cycle_count        = 0;
    x_neg              = 1'b0;
    y_neg              = 1'b1;

    // Shadow reset state.
    thr_reg    = tasd_pkg::THRESHOLD_RST;
    win_reg    = tasd_pkg::WINDOW_RST;
    lim_reg    = tasd_pkg::LIMIT_RST;
    fill_level = 0;
    for (m = 0; m < HIST_DEPTH; m++) begin
      x_hist[m] = '0;
      y_hist[m] = '0;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening under reset settings (threshold 8, window 16, limit 6).
    queue_move(-32768, 32767, 1'b0);   // not holding: extremes leave no trace
    queue_move(32767, -32768, 1'b0);
    queue_move(0, 0, 1'b1);
    queue_move(8, -8, 1'b1);           // exactly at threshold: no count
    queue_move(-9, 9, 1'b1);           // one above threshold, reversed: counts
    queue_move(32767, -32768, 1'b1);
    queue_move(-32768, 32767, 1'b1);
    queue_move(-1, 1, 1'b0);           // not holding in the middle of a run
    queue_move(32767, -32768, 1'b1);   // first sample after the previous holding move's shake: no count
    for (m = 0; m < 8; m++) begin
      queue_move((m % 2) ? -100 : 100, (m % 2) ? 100 : -100, 1'b1);
    end
    queue_move(0, 0, 1'b1);
    queue_move(-1, 1, 1'b1);
    queue_move(1, -1, 1'b1);
    queue_move(-32767, 32767, 1'b1);
    queue_move(0, -32768, 1'b1);
    wait_drained();

    // Random phases. Rotate the handshake pressure: none, sender idling,
    // receiver stalling, both.
    for (p = 0; p < NUM_PHASES; p++) begin
      thr = (phase_thr[p] < 0) ? $urandom_range(0, 400) : phase_thr[p];
      win = (phase_win[p] < 0) ? $urandom_range(0, 31) : phase_win[p];
      lim = (phase_lim[p] < 0) ? $urandom_range(0, 31) : phase_lim[p];
      write_registers(thr, win, lim);
      case (p % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 86;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 86;
        end
        default: begin
          sender_idle_pct    = 25;
          receiver_stall_pct = 25;
        end
      endcase
      for (m = 0; m < PHASE_MOVES; m++) begin
        dx = pick_delta(x_neg);
        dy = pick_delta(y_neg);
        queue_move(dx, dy, $urandom_range(0, 99) < 88);
      end
      wait_drained();
    end

    // Let the core settle; any stray result lands in the monitor.
    repeat (24) @(posedge clk);
    if (error_count == 0 && expected_shakes.size() == 0) begin
      $display("two_axis_shake_detector_core regression: pass");
    end else begin
      $display("two_axis_shake_detector_core regression: fail");
    end
    $finish;
  end

endmodule
